>>> rtl/tu64_pkg.sv
// Shared types and constants for the text-to-uint64 converter.
package tu64_pkg;

  localparam int CHAR_W  = 8;
  localparam int VAL_W   = 64;
  localparam int OFF_W   = 13;
  localparam int RADIX_W = 6;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] result_value;
    logic [OFF_W-1:0] end_offset;
    logic             overflowed;
  } out_item_t;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
  } cfg_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch the accepted character
    logic step;   // apply the character to the parse state
    logic emit;   // load the output register and clear the parse state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
  } stat_t;

endpackage

>>> rtl/tu64_chan_if.sv
// Valid/ready channel carrying one payload item.
interface tu64_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/tu64_ctrl.sv
// Controller: sequences accept, parse step and result hand-off.
module tu64_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  tu64_pkg::stat_t stat,
  output tu64_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_STEP, S_EMIT} state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);
  assign cmd.load = in_valid && in_ready;
  assign cmd.step = (state == S_STEP);
  assign cmd.emit = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.load) state <= S_STEP;
        end
        S_STEP: begin
          state <= stat.last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (cmd.emit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken item");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result loaded but valid not raised");

  a_accept_then_step: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.step)
    else $error("accepted item not stepped");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.emit}))
    else $error("overlapping datapath commands");

endmodule

>>> rtl/tu64_dp.sv
// Datapath: parse state, digit multiply-accumulate and result register.
module tu64_dp #(
  parameter int MAX_CHARS = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tu64_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  tu64_pkg::cfg_item_t                 cfg_data,
  input  tu64_pkg::cmd_t                      cmd,
  output tu64_pkg::stat_t                     stat,
  output tu64_pkg::out_item_t                 out_data
);

  localparam int PW = $clog2(MAX_CHARS + 1);
  localparam int OW = tu64_pkg::OFF_W;
  localparam int RW = tu64_pkg::RADIX_W;
  localparam int CW = tu64_pkg::CHAR_W;
  localparam int VW = tu64_pkg::VAL_W;

  localparam logic [CW-1:0] CH_NUL   = 8'h00;
  localparam logic [CW-1:0] CH_TAB   = 8'h09;
  localparam logic [CW-1:0] CH_CR    = 8'h0D;
  localparam logic [CW-1:0] CH_SPACE = 8'h20;
  localparam logic [CW-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CW-1:0] CH_0     = 8'h30;
  localparam logic [CW-1:0] CH_7     = 8'h37;
  localparam logic [CW-1:0] CH_9     = 8'h39;
  localparam logic [CW-1:0] CH_UA    = 8'h41;
  localparam logic [CW-1:0] CH_UX    = 8'h58;
  localparam logic [CW-1:0] CH_UZ    = 8'h5A;
  localparam logic [CW-1:0] CH_LA    = 8'h61;
  localparam logic [CW-1:0] CH_LX    = 8'h78;
  localparam logic [CW-1:0] CH_LZ    = 8'h7A;

  localparam logic [RW-1:0] BASE_AUTO = 6'd0;
  localparam logic [RW-1:0] BASE_ONE  = 6'd1;
  localparam logic [RW-1:0] BASE_MIN  = 6'd2;
  localparam logic [RW-1:0] BASE_8    = 6'd8;
  localparam logic [RW-1:0] BASE_10   = 6'd10;
  localparam logic [RW-1:0] BASE_16   = 6'd16;
  localparam logic [RW-1:0] BASE_MAX  = 6'd36;
  localparam logic [6:0]    DV_NONE   = 7'd99;

  typedef enum logic [2:0] {PH_WS, PH_SIGN, PH_ZERO, PH_ZEROX, PH_DIGITS, PH_DONE} phase_t;

  typedef struct packed {
    phase_t          ph;
    logic            neg;
    logic [RW-1:0]   bu;
    logic [PW-1:0]   sso;
    logic [PW-1:0]   so;
    logic            ds;
    logic            ov;
    logic [VW-1:0]   acc;
  } pst_t;

  localparam pst_t PST_CLR = '{ph: PH_WS, neg: 1'b0, bu: '0, sso: '0, so: '0,
                               ds: 1'b0, ov: 1'b0, acc: '0};

  function automatic logic [6:0] digit_val(logic [CW-1:0] c);
    logic [CW-1:0] d;
    d = CH_NUL;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + 8'd10;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA + 8'd10;
    end else begin
      d = {1'b0, DV_NONE};
    end
    return d[6:0];
  endfunction

  function automatic pst_t term(pst_t s, logic [PW-1:0] t);
    pst_t r;
    r = s;
    case (s.ph)
      PH_WS:     r.sso = t;
      PH_ZERO: begin
        r.ds = 1'b1;
        r.so = t;
      end
      PH_ZEROX:  r.ds = 1'b1;
      PH_DIGITS: r.so = t;
      default: ;
    endcase
    r.ph = PH_DONE;
    return r;
  endfunction

  // One 64x6 multiply-add; a carry into the top bits means overflow.
  function automatic pst_t take_digit(pst_t s, logic [6:0] dv, logic [PW-1:0] t);
    pst_t          r;
    logic [RW-1:0] bd;
    logic [69:0]   prod;
    logic [70:0]   sum;
    r    = s;
    bd   = (s.bu < BASE_MIN) ? BASE_10 : s.bu;
    prod = s.acc * bd;
    sum  = {1'b0, prod} + 71'(dv);
    if (dv >= 7'(bd)) begin
      r.so = t;
      r.ph = PH_DONE;
    end else if (|sum[70:64]) begin
      r.ov = 1'b1;
      r.so = t;
      r.ph = PH_DONE;
    end else begin
      r.acc = sum[63:0];
      r.ds  = 1'b1;
    end
    return r;
  endfunction

  logic [RW-1:0]       radix;
  logic [CW-1:0]       char_q;
  logic                last_q;
  logic [PW-1:0]       pos;
  logic [PW-1:0]       pos_next;
  pst_t                st;
  pst_t                st_next;
  tu64_pkg::out_item_t out_q;
  logic [6:0]          dv;
  logic                dig;
  logic                is_ws;

  assign stat.last = last_q;
  assign out_data  = out_q;
  assign pos_next  = (pos < PW'(MAX_CHARS)) ? pos + 1'b1 : PW'(MAX_CHARS);
  assign dv        = digit_val(char_q);
  assign is_ws     = (char_q == CH_SPACE) || (char_q >= CH_TAB && char_q <= CH_CR);

  always_comb begin
    st_next = st;
    dig     = 1'b0;
    // base is sampled from the register until the first non-space character
    if (st.ph == PH_WS) begin
      if (radix == BASE_ONE) begin
        st_next.bu = BASE_10;
      end else if (radix > BASE_MAX) begin
        st_next.bu = BASE_MAX;
      end else begin
        st_next.bu = radix;
      end
    end
    if (st.ph != PH_DONE) begin
      if (char_q == CH_NUL) begin
        st_next = term(st_next, pos);
      end else begin
        case (st.ph)
          PH_WS, PH_SIGN: begin
            if (st.ph == PH_WS && is_ws) begin
              st_next.ph = PH_WS;
            end else if (st.ph == PH_WS && char_q == CH_MINUS) begin
              st_next.sso = pos;
              st_next.neg = 1'b1;
              st_next.ph  = PH_SIGN;
            end else if (st.ph == PH_WS && char_q == CH_PLUS) begin
              st_next.sso = pos;
              st_next.ph  = PH_SIGN;
            end else begin
              if (st.ph == PH_WS) st_next.sso = pos;
              if (char_q == CH_0 &&
                  (st_next.bu == BASE_AUTO || st_next.bu == BASE_16)) begin
                st_next.ph = PH_ZERO;
              end else begin
                if (st_next.bu == BASE_AUTO) st_next.bu = BASE_10;
                st_next.ph = PH_DIGITS;
                dig        = 1'b1;
              end
            end
          end
          PH_ZERO: begin
            if (char_q == CH_LX || char_q == CH_UX) begin
              st_next.so = pos;
              st_next.ph = PH_ZEROX;
            end else begin
              st_next.ds = 1'b1;
              if (st_next.bu == BASE_AUTO) begin
                st_next.bu = (char_q >= CH_0 && char_q <= CH_7) ? BASE_8 : BASE_10;
              end
              st_next.ph = PH_DIGITS;
              dig        = 1'b1;
            end
          end
          PH_ZEROX: begin
            if (dv < 7'd16) begin
              st_next.bu = BASE_16;
              st_next.ph = PH_DIGITS;
              dig        = 1'b1;
            end else begin
              // bare "0x": value zero, stop stays at the x
              if (st_next.bu == BASE_AUTO) st_next.bu = BASE_10;
              st_next.ds = 1'b1;
              st_next.ph = PH_DONE;
            end
          end
          PH_DIGITS: dig = 1'b1;
          default: ;
        endcase
      end
    end
    if (dig) st_next = take_digit(st_next, dv, pos);
    if (last_q && st_next.ph != PH_DONE) st_next = term(st_next, pos_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= '0;
      st    <= PST_CLR;
      pos   <= '0;
    end else begin
      if (cfg_we) radix <= cfg_data.radix;
      if (cmd.step) begin
        st  <= st_next;
        pos <= pos_next;
      end
      if (cmd.emit) begin
        st  <= PST_CLR;
        pos <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_q <= in_data.in_char;
      last_q <= in_data.is_last;
    end
    if (cmd.emit) begin
      if (st.ov) begin
        out_q.result_value <= '1;
      end else if (st.neg && st.acc != '0) begin
        out_q.result_value <= ~st.acc + 1'b1;
      end else begin
        out_q.result_value <= st.acc;
      end
      out_q.end_offset <= OW'((st.ov || st.ds) ? st.so : st.sso);
      out_q.overflowed <= st.ov;
    end
  end

endmodule

>>> rtl/text_to_uint64_any_base.sv
// Streaming text to unsigned 64-bit converter, base 2..36 or auto-detected.
//
// in_ch carries one character per item (in_char, is_last). Leading
// whitespace and an optional sign are taken, the base is detected when
// radix is 0, and digits are accumulated until a non-digit, a NUL or the
// overflow point. out_ch gives one item per string, on its last character:
// result_value, end_offset and overflowed.
// cfg carries the radix register; it is always ready and should be written
// only while no string is in flight. The base is sampled while whitespace
// is skipped.
// Each character is accepted, then applied in one 64x6 multiply-add step;
// the next is taken only after that step. After a string's last character
// an emit step forms the signed result into the output register.
// The output register decouples the two sides: characters of the next
// string are taken while a result waits; a last character whose result
// finds the register still full holds until out_ch.ready.
// Reset (rst, synchronous) clears the radix to 0, the parse state and the
// output valid.
module text_to_uint64_any_base #(
  parameter int MAX_CHARS = 4096
) (
  input logic         clk,
  input logic         rst,
  tu64_chan_if.sink   in_ch,
  tu64_chan_if.source out_ch,
  tu64_chan_if.sink   cfg
);

  tu64_pkg::cmd_t  cmd;
  tu64_pkg::stat_t stat;

  assign cfg.ready = 1'b1;

  tu64_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tu64_dp #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_ch.data),
    .cfg_we   (cfg.valid && cfg.ready),
    .cfg_data (cfg.data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_ch.data)
  );

endmodule

>>> tb/text_to_uint64_any_base_test.sv
// Testbench for text_to_uint64_any_base: directed strings, then random strings per radix.
module text_to_uint64_any_base_test;

  localparam int MAX_CHARS = 4096;
  localparam int RANDOM_ITEMS = 1000;
  localparam int CALM_TAIL = 150;
  localparam int LONG_HOLD = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [63:0] ALL_ONES = {64{1'b1}};
  localparam byte unsigned NUL_MARK = "@";
  localparam logic [5:0] RADIX_PLAN [9] = '{6'd0, 6'd16, 6'd2, 6'd36, 6'd37, 6'd8, 6'd1, 6'd10,
                                            6'd63};

  typedef enum logic [2:0] {
    SKIP_WS, AFTER_SIGN, LEAD_ZERO, ZERO_X, IN_DIGITS, STOPPED
  } scan_phase_t;

  typedef struct {
    string       text;
    logic [5:0]  radix;
    bit          typed;
    logic [63:0] value;
    logic [12:0] offset;
    bit          ovf;
  } directed_row_t;

  // '@' in a row stands for NUL
  directed_row_t directed_rows [13] = '{
    '{"0",                   6'd0,  1'b1, 64'd0,    13'd1, 1'b0},
    '{"0x1F",                6'd0,  1'b0, 64'd0,    13'd0, 1'b0},
    '{"017",                 6'd0,  1'b0, 64'd0,    13'd0, 1'b0},
    '{"089",                 6'd0,  1'b0, 64'd0,    13'd0, 1'b0},
    '{"0xg",                 6'd0,  1'b0, 64'd0,    13'd0, 1'b0},
    '{"@",                   6'd0,  1'b1, 64'd0,    13'd0, 1'b0},
    '{"1@9",                 6'd0,  1'b0, 64'd0,    13'd0, 1'b0},
    '{"\t\n\v\f\015-7",      6'd10, 1'b0, 64'd0,    13'd0, 1'b0},
    '{"-1",                  6'd10, 1'b1, ALL_ONES, 13'd2, 1'b0},
    '{"0x",                  6'd16, 1'b0, 64'd0,    13'd0, 1'b0},
    '{"19",                  6'd1,  1'b0, 64'd0,    13'd0, 1'b0},
    '{"102",                 6'd2,  1'b0, 64'd0,    13'd0, 1'b0},
    '{"zZ",                  6'd63, 1'b0, 64'd0,    13'd0, 1'b0}
  };

  logic clk = 0;
  logic rst = 1;

  tu64_chan_if #(.T(tu64_pkg::in_item_t)) in_ch ();
  tu64_chan_if #(.T(tu64_pkg::out_item_t)) out_ch ();
  tu64_chan_if #(.T(tu64_pkg::cfg_item_t)) cfg_ch ();

  text_to_uint64_any_base #(.MAX_CHARS(MAX_CHARS)) DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg_ch)
  );

  always #5 clk = ~clk;

  // converter state as seen from outside
  logic [5:0]   radix_reg;
  logic [5:0]   base;
  logic [63:0]  acc;
  scan_phase_t  ph;
  bit           neg, seen, ovf;
  int unsigned  pos, sign_at, stop_at;

  tu64_pkg::out_item_t results_due [$];
  bit                  pinned = 0;
  tu64_pkg::out_item_t pinned_res;

  byte unsigned text_q [$];
  int           mismatches = 0;
  int           items_sent = 0;
  int           tx_idle_pct = 20;
  int           rx_idle_pct = 20;
  bit           long_hold_req = 0;
  int           quiet = 0;

  function automatic int unsigned digit_of(input byte unsigned c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "z") return c - "a" + 10;
    if (c >= "A" && c <= "Z") return c - "A" + 10;
    return 99;
  endfunction

  function automatic bit is_blank(input byte unsigned c);
    return c == " " || c == "\t" || c == "\n" || c == "\v" || c == "\f" || c == "\015";
  endfunction

  function automatic void reset_string();
    acc = 0;
    ph = SKIP_WS;
    neg = 0;
    base = 0;
    pos = 0;
    sign_at = 0;
    stop_at = 0;
    seen = 0;
    ovf = 0;
  endfunction

  function automatic void take_digit(input byte unsigned c, input int unsigned at);
    int unsigned v;
    logic [63:0] b;
    v = digit_of(c);
    b = (base < 2) ? 64'd10 : 64'(base);
    if (64'(v) >= b) begin
      stop_at = at;
      ph = STOPPED;
      return;
    end
    if (acc > (ALL_ONES - 64'(v)) / b) begin
      ovf = 1;
      stop_at = at;
      ph = STOPPED;
      return;
    end
    acc = acc * b + 64'(v);
    seen = 1;
  endfunction

  function automatic void first_char(input byte unsigned c, input int unsigned at);
    if (c == "0" && (base == 0 || base == 16)) begin
      ph = LEAD_ZERO;
      return;
    end
    if (base == 0) base = 10;
    ph = IN_DIGITS;
    take_digit(c, at);
  endfunction

  function automatic void take_char(input byte unsigned c, input int unsigned at);
    case (ph)
      SKIP_WS: begin
        if (is_blank(c)) return;
        sign_at = at;
        if (c == "-") begin
          neg = 1;
          ph = AFTER_SIGN;
        end else if (c == "+") begin
          ph = AFTER_SIGN;
        end else begin
          first_char(c, at);
        end
      end
      AFTER_SIGN: first_char(c, at);
      LEAD_ZERO: begin
        if (c == "x" || c == "X") begin
          stop_at = at;
          ph = ZERO_X;
        end else begin
          seen = 1;
          if (base == 0) base = (c >= "0" && c <= "7") ? 6'd8 : 6'd10;
          ph = IN_DIGITS;
          take_digit(c, at);
        end
      end
      ZERO_X: begin
        if (digit_of(c) < 16) begin
          base = 16;
          ph = IN_DIGITS;
          take_digit(c, at);
        end else begin
          // bare prefix: value 0, stop at the x
          if (base == 0) base = 10;
          seen = 1;
          ph = STOPPED;
        end
      end
      IN_DIGITS: take_digit(c, at);
      default: ;
    endcase
  endfunction

  function automatic void finish_string(input int unsigned at);
    case (ph)
      SKIP_WS: sign_at = at;
      LEAD_ZERO: begin
        seen = 1;
        stop_at = at;
      end
      ZERO_X: seen = 1;
      IN_DIGITS: stop_at = at;
      default: ;
    endcase
    ph = STOPPED;
  endfunction

  function automatic void convert_char(input byte unsigned c, input bit last);
    int unsigned at, nxt;
    tu64_pkg::out_item_t r;
    at = pos;
    nxt = (at < MAX_CHARS) ? at + 1 : MAX_CHARS;
    // radix is latched while whitespace is being skipped
    if (ph == SKIP_WS) base = (radix_reg == 1) ? 6'd10 : (radix_reg > 36) ? 6'd36 : radix_reg;
    if (ph != STOPPED) begin
      if (c == 0) finish_string(at);
      else take_char(c, at);
    end
    pos = nxt;
    if (!last) return;
    if (ph != STOPPED) finish_string(nxt);
    r.result_value = ovf ? ALL_ONES : (neg && acc != 0) ? -acc : acc;
    r.end_offset = 13'((ovf || seen) ? stop_at : sign_at);
    r.overflowed = ovf;
    if (pinned) begin
      results_due.push_back(pinned_res);
      pinned = 0;
    end else begin
      results_due.push_back(r);
    end
    reset_string();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      radix_reg = 0;
      reset_string();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) radix_reg = cfg_ch.data.radix;
      if (in_ch.valid && in_ch.ready) convert_char(in_ch.data.in_char, in_ch.data.is_last);
    end
  end

  always @(posedge clk) begin : check_results
    tu64_pkg::out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h offset %0d ovf %0b",
                   out_ch.data.result_value, out_ch.data.end_offset, out_ch.data.overflowed);
      end else begin
        want = results_due.pop_front();
        if (out_ch.data.result_value !== want.result_value ||
            out_ch.data.end_offset !== want.end_offset ||
            out_ch.data.overflowed !== want.overflowed) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h offset %0d ovf %0b, got %h %0d %0b",
                     want.result_value, want.end_offset, want.overflowed,
                     out_ch.data.result_value, out_ch.data.end_offset, out_ch.data.overflowed);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 0;
        hold_left--;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        out_ch.ready <= 0;
        hold_left = $urandom_range(0, 9);
      end else begin
        out_ch.ready <= 1;
      end
    end
  end

  function automatic byte unsigned any_space();
    case ($urandom_range(0, 5))
      0: return " ";
      1: return "\t";
      2: return "\n";
      3: return "\v";
      4: return "\f";
      default: return "\015";
    endcase
  endfunction

  function automatic byte unsigned glyph_of(input int unsigned v);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 30;
    endcase
  endfunction

  // mostly well-formed numbers with random content, some raw noise
  function automatic void make_text(input logic [5:0] rdx);
    int unsigned b, n, v;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) text_q.push_back(any_space());
    case ($urandom_range(0, 3))
      0: text_q.push_back("-");
      1: text_q.push_back("+");
      default: ;
    endcase
    b = (rdx == 1) ? 10 : (rdx > 36) ? 36 : rdx;
    if (b == 0 || b == 16) begin
      case ($urandom_range(0, 4))
        0: begin
          text_q.push_back("0");
          text_q.push_back($urandom_range(0, 1) ? "x" : "X");
          b = 16;
        end
        1: begin
          text_q.push_back("0");
          text_q.push_back("x");
          text_q.push_back(8'("g" + $urandom_range(0, 19)));
          return;
        end
        2: begin
          if (b == 0) begin
            text_q.push_back("0");
            b = 8;
          end
        end
        default: ;
      endcase
      if (b == 0) b = 10;
    end
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 8);
    repeat (n) begin
      v = ($urandom_range(0, 2) == 0) ? b - 1 : $urandom_range(0, b - 1);
      text_q.push_back(glyph_of(v));
    end
    case ($urandom_range(0, 5))
      0: text_q.push_back(8'($urandom_range(1, 255)));
      1: begin
        text_q.push_back(8'd0);
        text_q.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
  endfunction

  // tasks start and return just after a falling edge
  task automatic send_char(input byte unsigned c, input bit last);
    if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= '{in_char: c, is_last: last};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_text();
    for (int k = 0; k < text_q.size(); k++) send_char(text_q[k], k == text_q.size() - 1);
  endtask

  task automatic write_radix(input logic [5:0] r);
    cfg_ch.valid <= 1;
    cfg_ch.data.radix <= r;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 0;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin : stimulus
    int start, phase_no, phase_len, phase_start, n;
    logic [5:0] rdx, cur_radix;
    byte unsigned ch;
    in_ch.valid = 0;
    in_ch.data = '0;
    cfg_ch.valid = 0;
    cfg_ch.data = '0;
    rst = 1;
    repeat (11) @(negedge clk);
    rst <= 0;

    cur_radix = 0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].radix != cur_radix) begin
        wait_drained();
        write_radix(directed_rows[i].radix);
        cur_radix = directed_rows[i].radix;
      end
      pinned = directed_rows[i].typed;
      pinned_res = '{result_value: directed_rows[i].value,
                     end_offset: directed_rows[i].offset,
                     overflowed: directed_rows[i].ovf};
      n = directed_rows[i].text.len();
      for (int k = 0; k < n; k++) begin
        ch = directed_rows[i].text[k];
        if (ch == NUL_MARK) ch = 0;
        send_char(ch, k == n - 1);
      end
    end

    start = items_sent;
    phase_no = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      wait_drained();
      if (phase_no < 9) rdx = RADIX_PLAN[phase_no];
      else if ($urandom_range(0, 1)) rdx = 6'($urandom_range(0, 63));
      else rdx = RADIX_PLAN[$urandom_range(0, 8)];
      write_radix(rdx);
      tx_idle_pct = pick_idle();
      rx_idle_pct = pick_idle();
      if (phase_no == 1) long_hold_req = 1;
      phase_len = $urandom_range(40, 120);
      phase_start = items_sent;
      while (items_sent - phase_start < phase_len && items_sent - start < RANDOM_ITEMS) begin
        if (items_sent - start >= RANDOM_ITEMS - CALM_TAIL) begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        make_text(rdx);
        send_text();
      end
      phase_no++;
    end

    wait_drained();
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
